[hw/rtl/seg_pkg.sv]
// Shared definitions for the 2D segment intersection pipeline.
// Default geometry and result status codes; no dependencies.
package seg_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TOL_WIDTH       = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

    typedef enum logic [1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_PARALLEL = 2'd1,
        STATUS_MISS     = 2'd2
    } status_t;

endpackage

[hw/rtl/segment_intersection_2d.sv]
// Two segments in, one crossing result out: a fully pipelined fixed-point datapath.
// Depends on seg_pkg for defaults, the tolerance width and status codes.
//
// The block takes one segment pair per clock while the output is not stalled and
// returns one result per pair, in order. Six stages of differences, products, cross
// products, sign fix-up, tolerance bounds and hit test come first, then one
// restoring divider stage per bit of the QW-bit segment parameter, with
// QW = max(FRAC_BITS, 16) + 3 (19 at the default Q16.16), then the point multiply
// and the rounding and saturation stage. The whole pipeline advances whenever the
// output register is empty or taken, so a stalled result holds every stage and nothing
// is dropped or repeated. The tolerance register should be written only while no transaction is in flight.
module segment_intersection_2d #(
    parameter int COORD_WIDTH = seg_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = seg_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [seg_pkg::TOL_WIDTH-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_WIDTH-1:0]     s_first_start_x,
    input  logic signed [COORD_WIDTH-1:0]     s_first_start_y,
    input  logic signed [COORD_WIDTH-1:0]     s_first_end_x,
    input  logic signed [COORD_WIDTH-1:0]     s_first_end_y,
    input  logic signed [COORD_WIDTH-1:0]     s_second_start_x,
    input  logic signed [COORD_WIDTH-1:0]     s_second_start_y,
    input  logic signed [COORD_WIDTH-1:0]     s_second_end_x,
    input  logic signed [COORD_WIDTH-1:0]     s_second_end_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [COORD_WIDTH-1:0]     m_cross_x,
    output logic signed [COORD_WIDTH-1:0]     m_cross_y,
    output logic signed [FRAC_BITS+2:0]       m_first_param
);
    import seg_pkg::*;

    localparam int C   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int EW  = C + 1;                        // coordinate differences
    localparam int PW  = 2 * EW;                       // cross product terms
    localparam int DW  = 2 * C + 4;                    // den, n1, n2
    localparam int QW  = ((F > TOL_WIDTH) ? F : TOL_WIDTH) + 3;
    localparam int HW  = DW / 2;                       // den split for tolerance product
    localparam int PLW = TOL_WIDTH + HW;               // low partial product
    localparam int PHW = TOL_WIDTH + DW - HW;          // high partial product
    localparam int CW  = DW + F + QW + 1;              // hit test compare width
    localparam int RW  = CW + 1;                       // divider remainder
    localparam int VW  = DW + 1;                       // divisor 2*den
    localparam int MW  = EW + QW;                      // point products
    localparam int SW  = MW + 1;                       // point sum
    localparam logic signed [MW-1:0] HALF   = MW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (C - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (C - 1));

    logic adv;
    logic [TOL_WIDTH-1:0] tol_reg;

    // Stage 1: differences
    logic                 v1_reg;
    logic signed [C-1:0]  c0x_1_reg, c0y_1_reg;
    logic signed [EW-1:0] d1x_1_reg, d1y_1_reg, d2x_1_reg, d2y_1_reg, vx_1_reg, vy_1_reg;
    // Stage 2: products
    logic                 v2_reg;
    logic signed [C-1:0]  c0x_2_reg, c0y_2_reg;
    logic signed [EW-1:0] d1x_2_reg, d1y_2_reg;
    logic signed [PW-1:0] pa_2_reg, pb_2_reg, pc_2_reg, pd_2_reg, pe_2_reg, pf_2_reg;
    // Stage 3: cross products
    logic                 v3_reg;
    logic signed [C-1:0]  c0x_3_reg, c0y_3_reg;
    logic signed [EW-1:0] d1x_3_reg, d1y_3_reg;
    logic signed [DW-1:0] den_3_reg, n1_3_reg, n2_3_reg;
    // Stage 4: positive denominator
    logic                 v4_reg, par_4_reg;
    logic signed [C-1:0]  c0x_4_reg, c0y_4_reg;
    logic signed [EW-1:0] d1x_4_reg, d1y_4_reg;
    logic signed [DW-1:0] den_4_reg, n1_4_reg, n2_4_reg;
    // Stage 5: tolerance bounds as two partial products of tol * den
    logic                 v5_reg, par_5_reg;
    logic signed [C-1:0]  c0x_5_reg, c0y_5_reg;
    logic signed [EW-1:0] d1x_5_reg, d1y_5_reg;
    logic signed [DW-1:0] den_5_reg, n1_5_reg, n2_5_reg;
    logic [PLW-1:0]       tpl_5_reg;
    logic [PHW-1:0]       tph_5_reg;
    // Divider chain; index 0 is the hit test stage
    logic                 dv_v_reg   [0:QW];
    logic [1:0]           dv_st_reg  [0:QW];
    logic signed [C-1:0]  dv_c0x_reg [0:QW];
    logic signed [C-1:0]  dv_c0y_reg [0:QW];
    logic signed [EW-1:0] dv_d1x_reg [0:QW];
    logic signed [EW-1:0] dv_d1y_reg [0:QW];
    logic [RW-1:0]        dv_rem_reg [0:QW];
    logic [QW-1:0]        dv_quo_reg [0:QW];
    logic [VW-1:0]        dv_den_reg [0:QW];
    // Point multiply stage
    logic                 vm_reg;
    logic [1:0]           st_m_reg;
    logic signed [C-1:0]  c0x_m_reg, c0y_m_reg;
    logic signed [MW-1:0] mx_m_reg, my_m_reg;
    logic signed [QW-1:0] tq_m_reg;
    // Output register
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic signed [C-1:0]  m_cross_x_reg, m_cross_y_reg;
    logic signed [F+2:0]  m_first_param_reg;

    // Advance the whole pipe when the output slot is free or being taken
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Front stages: differences, products, cross products, sign, bounds
    always_ff @(posedge aclk) begin
        if (adv) begin
            c0x_1_reg <= s_first_start_x;
            c0y_1_reg <= s_first_start_y;
            d1x_1_reg <= EW'(s_first_end_x) - EW'(s_first_start_x);
            d1y_1_reg <= EW'(s_first_end_y) - EW'(s_first_start_y);
            d2x_1_reg <= EW'(s_second_end_x) - EW'(s_second_start_x);
            d2y_1_reg <= EW'(s_second_end_y) - EW'(s_second_start_y);
            vx_1_reg  <= EW'(s_second_start_x) - EW'(s_first_start_x);
            vy_1_reg  <= EW'(s_second_start_y) - EW'(s_first_start_y);

            c0x_2_reg <= c0x_1_reg;
            c0y_2_reg <= c0y_1_reg;
            d1x_2_reg <= d1x_1_reg;
            d1y_2_reg <= d1y_1_reg;
            pa_2_reg  <= d1x_1_reg * d2y_1_reg;
            pb_2_reg  <= d1y_1_reg * d2x_1_reg;
            pc_2_reg  <= vx_1_reg * d2y_1_reg;
            pd_2_reg  <= vy_1_reg * d2x_1_reg;
            pe_2_reg  <= vx_1_reg * d1y_1_reg;
            pf_2_reg  <= vy_1_reg * d1x_1_reg;

            c0x_3_reg <= c0x_2_reg;
            c0y_3_reg <= c0y_2_reg;
            d1x_3_reg <= d1x_2_reg;
            d1y_3_reg <= d1y_2_reg;
            den_3_reg <= DW'(pa_2_reg) - DW'(pb_2_reg);
            n1_3_reg  <= DW'(pc_2_reg) - DW'(pd_2_reg);
            n2_3_reg  <= DW'(pe_2_reg) - DW'(pf_2_reg);

            c0x_4_reg <= c0x_3_reg;
            c0y_4_reg <= c0y_3_reg;
            d1x_4_reg <= d1x_3_reg;
            d1y_4_reg <= d1y_3_reg;
            par_4_reg <= (den_3_reg == '0);
            den_4_reg <= den_3_reg[DW-1] ? -den_3_reg : den_3_reg;
            n1_4_reg  <= den_3_reg[DW-1] ? -n1_3_reg : n1_3_reg;
            n2_4_reg  <= den_3_reg[DW-1] ? -n2_3_reg : n2_3_reg;

            c0x_5_reg <= c0x_4_reg;
            c0y_5_reg <= c0y_4_reg;
            d1x_5_reg <= d1x_4_reg;
            d1y_5_reg <= d1y_4_reg;
            par_5_reg <= par_4_reg;
            den_5_reg <= den_4_reg;
            n1_5_reg  <= n1_4_reg;
            n2_5_reg  <= n2_4_reg;
            tpl_5_reg <= PLW'(tol_reg) * PLW'(den_4_reg[HW-1:0]);
            tph_5_reg <= PHW'(tol_reg) * PHW'(den_4_reg[DW-1:HW]);
        end
    end

    // Hit test and divider set-up; quotient is offset by 2^(QW-1) to stay unsigned
    logic signed [CW-1:0] a1_w, a2_w, tl_w, lo_w, hi_w;
    logic                 miss_w;
    logic [1:0]           st6_w;
    logic signed [RW-1:0] num_w;

    always_comb begin
        a1_w   = CW'(n1_5_reg) <<< F;
        a2_w   = CW'(n2_5_reg) <<< F;
        tl_w   = CW'(tpl_5_reg) + (CW'(tph_5_reg) << HW);
        lo_w   = -tl_w;
        hi_w   = tl_w + (CW'(den_5_reg) <<< F);
        miss_w = (a1_w < lo_w) || (hi_w < a1_w) || (a2_w < lo_w) || (hi_w < a2_w);
        if (par_5_reg) begin
            st6_w = STATUS_PARALLEL;
        end else if (miss_w) begin
            st6_w = STATUS_MISS;
        end else begin
            st6_w = STATUS_HIT;
        end
        num_w = (RW'(a1_w) <<< 1) + RW'(den_5_reg) + (RW'(den_5_reg) <<< QW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_st_reg[0]  <= st6_w;
            dv_c0x_reg[0] <= c0x_5_reg;
            dv_c0y_reg[0] <= c0y_5_reg;
            dv_d1x_reg[0] <= d1x_5_reg;
            dv_d1y_reg[0] <= d1y_5_reg;
            dv_rem_reg[0] <= num_w;
            dv_quo_reg[0] <= '0;
            dv_den_reg[0] <= {den_5_reg, 1'b0};
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first
    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int K = QW - 1 - i;
        logic [RW-1:0] sub_w;
        logic          take_w;

        always_comb begin
            sub_w  = RW'(dv_den_reg[i]) << K;
            take_w = (dv_rem_reg[i] >= sub_w);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_st_reg[i+1]  <= dv_st_reg[i];
                dv_c0x_reg[i+1] <= dv_c0x_reg[i];
                dv_c0y_reg[i+1] <= dv_c0y_reg[i];
                dv_d1x_reg[i+1] <= dv_d1x_reg[i];
                dv_d1y_reg[i+1] <= dv_d1y_reg[i];
                dv_den_reg[i+1] <= dv_den_reg[i];
                dv_rem_reg[i+1] <= take_w ? (dv_rem_reg[i] - sub_w) : dv_rem_reg[i];
                dv_quo_reg[i+1] <= dv_quo_reg[i] | (QW'(take_w) << K);
            end
        end
    end

    // Remove the quotient offset and scale the first direction
    logic signed [QW-1:0] tq_w;
    assign tq_w = $signed({~dv_quo_reg[QW][QW-1], dv_quo_reg[QW][QW-2:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (adv) begin
            vm_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_m_reg  <= dv_st_reg[QW];
            c0x_m_reg <= dv_c0x_reg[QW];
            c0y_m_reg <= dv_c0y_reg[QW];
            tq_m_reg  <= tq_w;
            mx_m_reg  <= dv_d1x_reg[QW] * tq_w;
            my_m_reg  <= dv_d1y_reg[QW] * tq_w;
        end
    end

    // Round, offset by the first start point, saturate
    logic signed [MW-1:0] rx_w, ry_w;
    logic signed [SW-1:0] sx_w, sy_w;
    logic signed [C-1:0]  px_w, py_w;
    logic                 hit_w;

    always_comb begin
        rx_w  = (mx_m_reg + HALF) >>> F;
        ry_w  = (my_m_reg + HALF) >>> F;
        sx_w  = SW'(c0x_m_reg) + SW'(rx_w);
        sy_w  = SW'(c0y_m_reg) + SW'(ry_w);
        if (sx_w > SAT_HI) begin
            px_w = C'(SAT_HI);
        end else if (sx_w < SAT_LO) begin
            px_w = C'(SAT_LO);
        end else begin
            px_w = C'(sx_w);
        end
        if (sy_w > SAT_HI) begin
            py_w = C'(SAT_HI);
        end else if (sy_w < SAT_LO) begin
            py_w = C'(SAT_LO);
        end else begin
            py_w = C'(sy_w);
        end
        hit_w = (st_m_reg == STATUS_HIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_status_reg      <= st_m_reg;
            m_cross_x_reg     <= hit_w ? px_w : '0;
            m_cross_y_reg     <= hit_w ? py_w : '0;
            m_first_param_reg <= hit_w ? tq_m_reg[F+2:0] : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_cross_x     = m_cross_x_reg;
    assign m_cross_y     = m_cross_y_reg;
    assign m_first_param = m_first_param_reg;

`ifndef SYNTHESIS
    // A result that is not a crossing carries zero point and parameter
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_HIT) |->
            (m_cross_x == '0 && m_cross_y == '0 && m_first_param == '0))
        else $error("non-crossing result with non-zero payload");

    // Only the three defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_HIT || m_status == STATUS_PARALLEL ||
                     m_status == STATUS_MISS))
        else $error("undefined status code");

    // A held result blocks intake in the same cycle
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("transaction accepted while result stalled");

    // A stalled pipe keeps its valid bits in place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vm_reg) && $stable(dv_v_reg[0]))
        else $error("pipeline moved during stall");
`endif

endmodule
